### sv/slcg_pkg.sv
// ----------------------------------------------------------------------------
// slcg_pkg: shared types and constants for the shuffled three-LCG source
// Generator constants, reciprocals for the modulo reduction unit, and the
// request/result structs that pass between the sequencer and the unit.
// ----------------------------------------------------------------------------
package slcg_pkg;

	localparam logic [17:0] MOD_ONE   = 18'd259200;
	localparam logic [12:0] MUL_ONE   = 13'd7141;
	localparam logic [15:0] ADD_ONE   = 16'd54773;
	localparam logic [17:0] MOD_TWO   = 18'd134456;
	localparam logic [12:0] MUL_TWO   = 13'd8121;
	localparam logic [15:0] ADD_TWO   = 16'd28411;
	localparam logic [17:0] MOD_THREE = 18'd243000;
	localparam logic [12:0] MUL_THREE = 13'd4561;
	localparam logic [15:0] ADD_THREE = 16'd51349;

	// floor(2^33 / modulus); quotient estimate is low by at most one
	localparam int unsigned RECIP_SHIFT = 33;
	localparam logic [15:0] RECIP_ONE   = 16'd33140;
	localparam logic [15:0] RECIP_TWO   = 16'd63886;
	localparam logic [15:0] RECIP_THREE = 16'd35349;

	// multiple of MOD_ONE that lifts 54773 - seed into 0 .. 2^33-1
	localparam logic [33:0] SEED_OFFSET = 34'd2147472000;

	// MOD_ONE * MOD_TWO, denominator of the fraction
	localparam logic [35:0] FRAC_DEN  = 36'd34850995200;
	localparam int unsigned FRAC_BITS = 24;

	// FRAC_DEN = 2^10 * FRAC_DIV, so frac = floor(2^14 * num / FRAC_DIV)
	localparam logic [25:0] FRAC_DIV   = 26'(FRAC_DEN >> 10);
	// floor(2^50 / FRAC_DIV); num * FRAC_RECIP >> 36 is low by at most one
	localparam logic [24:0] FRAC_RECIP = 25'((64'd1 << 50) / 64'(FRAC_DIV));

	typedef enum logic [1:0] {
		SEL_ONE   = 2'd0,
		SEL_TWO   = 2'd1,
		SEL_THREE = 2'd2
	} mod_sel_t;

	typedef struct packed {
		logic        direct;   // reduce operand as is, else operand*mul+add
		logic [32:0] operand;
		logic [12:0] mul;
		logic [15:0] add;
		mod_sel_t    sel;
	} op_req_t;

	typedef struct packed {
		logic [15:0] quo;
		logic [17:0] rem;
	} op_res_t;

	function automatic logic [17:0] mod_of(input mod_sel_t sel);
		logic [17:0] m;
		case (sel)
			SEL_ONE:   m = MOD_ONE;
			SEL_TWO:   m = MOD_TWO;
			SEL_THREE: m = MOD_THREE;
			default:   m = MOD_ONE;
		endcase
		return m;
	endfunction

	function automatic logic [15:0] recip_of(input mod_sel_t sel);
		logic [15:0] r;
		case (sel)
			SEL_ONE:   r = RECIP_ONE;
			SEL_TWO:   r = RECIP_TWO;
			SEL_THREE: r = RECIP_THREE;
			default:   r = RECIP_ONE;
		endcase
		return r;
	endfunction

endpackage

### sv/slcg_modu.sv
// ----------------------------------------------------------------------------
// slcg_modu: shared multiply-add and constant-modulus reduction unit
// Five-stage pipe: operand build, reciprocal multiply, quotient times modulus,
// subtract, and a single correction step. Returns quotient and remainder.
// ----------------------------------------------------------------------------
module slcg_modu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  slcg_pkg::op_req_t req,
	output logic              done,
	output slcg_pkg::op_res_t res
);
	import slcg_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [32:0] p_s1, p_s2, p_s3;
	mod_sel_t    sel_s1, sel_s2, sel_s3, sel_s4;
	logic [15:0] q_s2, q_s3, q_s4;
	logic [33:0] qm_s3;
	logic [18:0] diff_s4;

	logic [30:0] lin_prod;
	logic [32:0] p_in;
	logic [48:0] recip_prod;
	logic [32:0] diff_full;
	logic [17:0] mod_s4;

	always_comb begin
		lin_prod   = 31'(req.operand[17:0]) * 31'(req.mul);
		p_in       = req.direct ? req.operand : (33'(lin_prod) + 33'(req.add));
		recip_prod = 49'(p_s1) * 49'(recip_of(sel_s1));
		diff_full  = p_s3 - qm_s3[32:0];
		mod_s4     = mod_of(sel_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			done    <= 1'b0;
			p_s1    <= '0;
			p_s2    <= '0;
			p_s3    <= '0;
			sel_s1  <= SEL_ONE;
			sel_s2  <= SEL_ONE;
			sel_s3  <= SEL_ONE;
			sel_s4  <= SEL_ONE;
			q_s2    <= '0;
			q_s3    <= '0;
			q_s4    <= '0;
			qm_s3   <= '0;
			diff_s4 <= '0;
			res     <= '0;
		end else begin
			v_s1   <= start;
			p_s1   <= p_in;
			sel_s1 <= req.sel;

			v_s2   <= v_s1;
			p_s2   <= p_s1;
			sel_s2 <= sel_s1;
			q_s2   <= recip_prod[48:RECIP_SHIFT];

			v_s3   <= v_s2;
			p_s3   <= p_s2;
			sel_s3 <= sel_s2;
			q_s3   <= q_s2;
			qm_s3  <= 34'(q_s2) * 34'(mod_of(sel_s2));

			// true remainder is below twice the modulus here
			v_s4    <= v_s3;
			sel_s4  <= sel_s3;
			q_s4    <= q_s3;
			diff_s4 <= diff_full[18:0];

			done <= v_s4;
			if (diff_s4 >= 19'(mod_s4)) begin
				res.rem <= 18'(diff_s4 - 19'(mod_s4));
				res.quo <= q_s4 + 16'd1;
			end else begin
				res.rem <= diff_s4[17:0];
				res.quo <= q_s4;
			end
		end
	end

endmodule

### sv/slcg_fdiv.sv
// ----------------------------------------------------------------------------
// slcg_fdiv: fraction unit
// Reciprocal multiply of num by 2^14/FRAC_DIV in two 18-bit halves, then one
// compare-and-correct step, giving the truncated 24-bit fraction.
// ----------------------------------------------------------------------------
module slcg_fdiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [35:0] num,
	output logic        done,
	output logic [23:0] frac
);
	import slcg_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_LO   = 5'b00010,
		PH_HI   = 5'b00100,
		PH_MUL  = 5'b01000,
		PH_FIX  = 5'b10000
	} phase_t;

	phase_t      ph_q;
	logic [35:0] num_q;
	logic [24:0] part_q;
	logic [41:0] sum_q;
	logic [26:0] qc_q;
	logic [17:0] mul_a;
	logic [42:0] mult;
	logic [23:0] q_est;
	logic [26:0] qc_low;
	logic [26:0] diff;

	always_comb begin
		mul_a  = (ph_q == PH_HI) ? num_q[35:18] : num_q[17:0];
		mult   = 43'(mul_a) * 43'(FRAC_RECIP);
		q_est  = sum_q[41:18];
		// remainder is below twice FRAC_DIV, so 27 low bits are enough
		qc_low = 27'(q_est) * 27'(FRAC_DIV);
		diff   = {num_q[12:0], 14'd0} - qc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			num_q  <= '0;
			part_q <= '0;
			sum_q  <= '0;
			qc_q   <= '0;
			done   <= 1'b0;
			frac   <= '0;
		end else begin
			done <= (ph_q == PH_FIX);
			case (ph_q)
				PH_IDLE: begin
					if (start) begin
						num_q <= num;
						ph_q  <= PH_LO;
					end
				end
				PH_LO: begin
					part_q <= mult[42:18];
					ph_q   <= PH_HI;
				end
				PH_HI: begin
					sum_q <= 42'(mult) + 42'(part_q);
					ph_q  <= PH_MUL;
				end
				PH_MUL: begin
					qc_q <= qc_low;
					ph_q <= PH_FIX;
				end
				PH_FIX: begin
					frac <= (diff >= 27'(FRAC_DIV)) ? q_est + 24'd1 : q_est;
					ph_q <= PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

endmodule

### sv/shuffled_three_lcg_random.sv
// ----------------------------------------------------------------------------
// shuffled_three_lcg_random: three-LCG random source with a shuffle table
// Sequencer, shuffle table and output register around the shared reduction
// unit and the fraction unit.
// ----------------------------------------------------------------------------
// One request beat yields one response beat. The block handles one request at
// a time and holds req_stall high until that request's result is loaded into
// the output register. Every generator step, seed reduction and slot-index
// computation goes through the single multiply/modulo unit, and the fraction
// comes from a separate reciprocal-multiply unit. A plain draw runs four unit
// operations, table read and refill, fraction and output load in turn, and
// takes longer while a previous response beat is still stalled. A negative
// seed, or the first request after reset, reseeds first: five unit operations
// of seed reduction and generator steps, then 2*SLOT_COUNT generator steps
// that fill the table one slot per two operations.
// ----------------------------------------------------------------------------
module shuffled_three_lcg_random #(
	parameter int SLOT_COUNT = 97
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic signed [31:0] seed,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic        [17:0] high_part,
	output logic        [17:0] low_part,
	output logic        [23:0] fraction
);
	import slcg_pkg::*;

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic [15:0] {
		ST_IDLE      = 16'b0000_0000_0000_0001,
		ST_RS_LOAD   = 16'b0000_0000_0000_0010,
		ST_RS_STEP_A = 16'b0000_0000_0000_0100,
		ST_RS_MOD2   = 16'b0000_0000_0000_1000,
		ST_RS_STEP_B = 16'b0000_0000_0001_0000,
		ST_RS_MOD3   = 16'b0000_0000_0010_0000,
		ST_FILL_ONE  = 16'b0000_0000_0100_0000,
		ST_FILL_TWO  = 16'b0000_0000_1000_0000,
		ST_DR_ONE    = 16'b0000_0001_0000_0000,
		ST_DR_TWO    = 16'b0000_0010_0000_0000,
		ST_DR_THREE  = 16'b0000_0100_0000_0000,
		ST_DR_INDEX  = 16'b0000_1000_0000_0000,
		ST_DR_READ   = 16'b0001_0000_0000_0000,
		ST_DR_MUL    = 16'b0010_0000_0000_0000,
		ST_DR_DIV    = 16'b0100_0000_0000_0000,
		ST_DR_OUT    = 16'b1000_0000_0000_0000
	} state_t;

	state_t      state_q;
	logic        pend_q;
	logic        seeded_q;
	logic [31:0] seed_q;
	logic [17:0] x1_q, x2_q, x3_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] fill_q;
	logic [17:0] hi_q, lo_q;
	logic [35:0] num_q;
	logic [35:0] rd_q;

	logic [35:0] slot_mem [SLOT_COUNT];

	op_req_t     op_req;
	op_res_t     op_res;
	logic        op_state;
	logic        op_start;
	logic        op_done;
	logic        div_start;
	logic        div_done;
	logic [23:0] div_frac;
	logic [33:0] seed_lift;
	logic        mem_we;
	logic [IW-1:0] mem_waddr;
	logic [35:0] mem_wdata;

	assign req_stall = (state_q != ST_IDLE);

	// 54773 - seed, shifted up by a multiple of the first modulus
	assign seed_lift = 34'(ADD_ONE) - {{2{seed_q[31]}}, seed_q} + SEED_OFFSET;

	always_comb begin
		op_req   = '0;
		op_state = 1'b1;
		case (state_q)
			ST_RS_LOAD: begin
				op_req.direct  = 1'b1;
				op_req.operand = seed_lift[32:0];
				op_req.sel     = SEL_ONE;
			end
			ST_RS_STEP_A, ST_RS_STEP_B, ST_FILL_ONE, ST_DR_ONE: begin
				op_req.operand = 33'(x1_q);
				op_req.mul     = MUL_ONE;
				op_req.add     = ADD_ONE;
				op_req.sel     = SEL_ONE;
			end
			ST_RS_MOD2: begin
				op_req.direct  = 1'b1;
				op_req.operand = 33'(x1_q);
				op_req.sel     = SEL_TWO;
			end
			ST_RS_MOD3: begin
				op_req.direct  = 1'b1;
				op_req.operand = 33'(x1_q);
				op_req.sel     = SEL_THREE;
			end
			ST_FILL_TWO, ST_DR_TWO: begin
				op_req.operand = 33'(x2_q);
				op_req.mul     = MUL_TWO;
				op_req.add     = ADD_TWO;
				op_req.sel     = SEL_TWO;
			end
			ST_DR_THREE: begin
				op_req.operand = 33'(x3_q);
				op_req.mul     = MUL_THREE;
				op_req.add     = ADD_THREE;
				op_req.sel     = SEL_THREE;
			end
			ST_DR_INDEX: begin
				// slot = floor(SLOT_COUNT * x3 / 243000), the quotient
				op_req.operand = 33'(x3_q);
				op_req.mul     = 13'(SLOT_COUNT);
				op_req.sel     = SEL_THREE;
			end
			default: op_state = 1'b0;
		endcase
	end

	assign op_start  = op_state && !pend_q;
	assign div_start = (state_q == ST_DR_DIV) && !pend_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q;
		mem_wdata = {x1_q, op_res.rem};
		if (state_q == ST_DR_MUL) begin
			mem_we    = 1'b1;
			mem_waddr = idx_q;
			mem_wdata = {x1_q, x2_q};
		end else if (state_q == ST_FILL_TWO && pend_q && op_done) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			slot_mem[mem_waddr] <= mem_wdata;
		rd_q <= slot_mem[idx_q];
	end

	slcg_modu u_modu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (op_start),
		.req    (op_req),
		.done   (op_done),
		.res    (op_res)
	);

	slcg_fdiv u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.done   (div_done),
		.frac   (div_frac)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pend_q    <= 1'b0;
			seeded_q  <= 1'b0;
			seed_q    <= '0;
			x1_q      <= '0;
			x2_q      <= '0;
			x3_q      <= '0;
			idx_q     <= '0;
			fill_q    <= '0;
			hi_q      <= '0;
			lo_q      <= '0;
			num_q     <= '0;
			rsp_valid <= 1'b0;
			high_part <= '0;
			low_part  <= '0;
			fraction  <= '0;
		end else begin
			if (rsp_valid && !rsp_stall && state_q != ST_DR_OUT)
				rsp_valid <= 1'b0;

			if (op_start || div_start)
				pend_q <= 1'b1;

			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						seed_q  <= seed;
						state_q <= (seed[31] || !seeded_q) ? ST_RS_LOAD : ST_DR_ONE;
					end
				end
				ST_DR_READ: state_q <= ST_DR_MUL;
				ST_DR_MUL: begin
					// table word read last cycle, slot refilled now
					hi_q    <= rd_q[35:18];
					lo_q    <= rd_q[17:0];
					num_q   <= 36'(rd_q[35:18]) * 36'(MOD_TWO) + 36'(rd_q[17:0]);
					state_q <= ST_DR_DIV;
				end
				ST_DR_DIV: begin
					if (pend_q && div_done) begin
						pend_q  <= 1'b0;
						state_q <= ST_DR_OUT;
					end
				end
				ST_DR_OUT: begin
					if (!rsp_valid || !rsp_stall) begin
						rsp_valid <= 1'b1;
						high_part <= hi_q;
						low_part  <= lo_q;
						fraction  <= div_frac;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					if (pend_q && op_done) begin
						pend_q <= 1'b0;
						case (state_q)
							ST_RS_LOAD: begin
								x1_q    <= op_res.rem;
								state_q <= ST_RS_STEP_A;
							end
							ST_RS_STEP_A: begin
								x1_q    <= op_res.rem;
								state_q <= ST_RS_MOD2;
							end
							ST_RS_MOD2: begin
								x2_q    <= op_res.rem;
								state_q <= ST_RS_STEP_B;
							end
							ST_RS_STEP_B: begin
								x1_q    <= op_res.rem;
								state_q <= ST_RS_MOD3;
							end
							ST_RS_MOD3: begin
								x3_q    <= op_res.rem;
								fill_q  <= '0;
								state_q <= ST_FILL_ONE;
							end
							ST_FILL_ONE: begin
								x1_q    <= op_res.rem;
								state_q <= ST_FILL_TWO;
							end
							ST_FILL_TWO: begin
								x2_q <= op_res.rem;
								if (fill_q == IW'(SLOT_COUNT - 1)) begin
									seeded_q <= 1'b1;
									state_q  <= ST_DR_ONE;
								end else begin
									fill_q  <= fill_q + 1'b1;
									state_q <= ST_FILL_ONE;
								end
							end
							ST_DR_ONE: begin
								x1_q    <= op_res.rem;
								state_q <= ST_DR_TWO;
							end
							ST_DR_TWO: begin
								x2_q    <= op_res.rem;
								state_q <= ST_DR_THREE;
							end
							ST_DR_THREE: begin
								x3_q    <= op_res.rem;
								state_q <= ST_DR_INDEX;
							end
							ST_DR_INDEX: begin
								idx_q   <= op_res.quo[IW-1:0];
								state_q <= ST_DR_READ;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
			endcase
		end
	end

endmodule

### sv/slcg_chk.sv
// ----------------------------------------------------------------------------
// slcg_chk: port-level checks for the shuffled three-LCG source
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module slcg_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic [31:0] seed,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [17:0] high_part,
	input logic [17:0] low_part,
	input logic [23:0] fraction
);
	import slcg_pkg::*;

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(high_part)
			&& $stable(low_part) && $stable(fraction)))
		else $error("response beat changed while stalled");

	// generator values stay inside their moduli
	a_rsp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (high_part < MOD_ONE && low_part < MOD_TWO))
		else $error("response value out of range");

	// one request at a time: busy right after a beat is taken
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while previous one in flight");

	// a result needs unit work after the request beat, so rsp_valid does not rise at once
	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> !$rose(rsp_valid))
		else $error("response appeared right after request");

endmodule

bind shuffled_three_lcg_random slcg_chk u_slcg_chk (.*);

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: shuffled three-LCG random source
// Sends seed beats with random gaps and a randomly stalled response side.
// A local copy of the generators and shuffle table predicts every response
// beat, which is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
	import slcg_pkg::*;

	localparam int SLOTS      = 97;
	localparam int IDLE_LIMIT = 20000;
	localparam int TAIL_WAIT  = 100;
	localparam int RAND_ITEMS = 1400;

	typedef struct packed {
		logic [17:0] hi;
		logic [17:0] lo;
		logic [23:0] frac;
	} draw_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic signed [31:0] seed      = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic        [17:0] high_part;
	logic        [17:0] low_part;
	logic        [23:0] fraction;

	// predictor state
	logic [17:0] lcg1_q     = '0;
	logic [17:0] lcg2_q     = '0;
	logic [17:0] lcg3_q     = '0;
	logic        tbl_loaded = 1'b0;
	logic [17:0] tbl_hi [SLOTS];
	logic [17:0] tbl_lo [SLOTS];

	draw_t pending_draws [$];
	int    error_count  = 0;
	bit    idle_en      = 1'b1;
	int    rsp_hold     = 0;
	int    quiet_cycles = 0;

	shuffled_three_lcg_random #(
		.SLOT_COUNT(SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.seed     (seed),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.high_part(high_part),
		.low_part (low_part),
		.fraction (fraction)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [17:0] lcg_next(input logic [17:0] x, input logic [12:0] mul,
			input logic [15:0] add, input logic [17:0] m);
		longint unsigned p;
		p = longint'(x) * mul + add;
		return 18'(p % m);
	endfunction

	task automatic step_first();
		lcg1_q = lcg_next(lcg1_q, MUL_ONE, ADD_ONE, MOD_ONE);
	endtask

	task automatic step_second();
		lcg2_q = lcg_next(lcg2_q, MUL_TWO, ADD_TWO, MOD_TWO);
	endtask

	task automatic reload_table(input logic signed [31:0] s);
		longint d;
		longint r;
		longint m;
		m = longint'(MOD_ONE);
		d = longint'(ADD_ONE) - longint'(s);
		r = d % m;
		// first seed may be large and positive: keep the remainder non-negative
		if (r < 0) r += m;
		lcg1_q = r[17:0];
		step_first();
		lcg2_q = lcg1_q % MOD_TWO;
		step_first();
		lcg3_q = lcg1_q % MOD_THREE;
		for (int i = 0; i < SLOTS; i++) begin
			step_first();
			step_second();
			tbl_hi[i] = lcg1_q;
			tbl_lo[i] = lcg2_q;
		end
		tbl_loaded = 1'b1;
	endtask

	task automatic predict_draw(input logic signed [31:0] s, output draw_t d);
		longint unsigned idx;
		longint unsigned num;
		if (s < 0 || !tbl_loaded) reload_table(s);
		step_first();
		step_second();
		lcg3_q = lcg_next(lcg3_q, MUL_THREE, ADD_THREE, MOD_THREE);
		idx = (longint'(lcg3_q) * SLOTS) / MOD_THREE;
		d.hi = tbl_hi[idx];
		d.lo = tbl_lo[idx];
		tbl_hi[idx] = lcg1_q;
		tbl_lo[idx] = lcg2_q;
		num = (longint'(d.hi) * MOD_TWO + d.lo) << FRAC_BITS;
		d.frac = 24'(num / FRAC_DEN);
	endtask

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (!idle_en) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [31:0] rand_seed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 7) return $urandom | 32'h8000_0000;
		if (r < 9) begin
			case ($urandom_range(0, 3))
				0:       return 32'sh8000_0000;
				1:       return -32'sd1;
				2:       return 32'sh7fff_ffff;
				default: return 32'sd0;
			endcase
		end
		return $urandom & 32'h7fff_ffff;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		error_count++;
	endtask

	task automatic send_draw(input logic signed [31:0] s);
		draw_t d;
		int    gap;
		seed      <= s;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_draw(s, d);
		pending_draws.push_back(d);
		gap = pick_gap();
		// zero gap: valid stays up for the next beat
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_draws.size() != 0);
	endtask

	task automatic test_unseeded_start();
		// never seeded, positive seed: reseeds, 54773 - seed is negative
		send_draw(32'sh7fff_ffff);
		send_draw(32'sd0);
		send_draw(32'sd1);
	endtask

	task automatic test_seed_extremes();
		send_draw(32'sh8000_0000);
		send_draw(32'sh7fff_ffff);
		send_draw(-32'sd1);
		send_draw(32'sd0);
		// first generator starts from zero
		send_draw(-32'sd204427);
		send_draw(32'sd54773);
		send_draw(-32'sd54773);
		send_draw(32'sh5555_5555);
		send_draw(32'shaaaa_aaaa);
		send_draw(32'sh2aaa_aaaa);
		drain();
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		send_draw(-32'sd7);
		for (int i = 0; i < 10; i++) send_draw($urandom & 32'h7fff_ffff);
		drain();
		idle_en = 1'b1;
	endtask

	task automatic test_random_draws(input int n);
		for (int i = 0; i < n; i++) begin
			send_draw(rand_seed());
			if (i == n / 2) drain();
			if (i == (3 * n) / 4) idle_en = 1'b0;
			if (i == (3 * n) / 4 + 60) idle_en = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp_hold--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			rsp_hold = pick_gap();
		end
	end

	always @(posedge clk) begin : check_beat
		draw_t want;
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_draws.size() == 0) begin
				report_mismatch($sformatf("unexpected beat hi=%0d lo=%0d frac=%0d",
					high_part, low_part, fraction));
			end else begin
				want = pending_draws.pop_front();
				if (high_part !== want.hi)
					report_mismatch($sformatf("high_part %0d, want %0d", high_part, want.hi));
				if (low_part !== want.lo)
					report_mismatch($sformatf("low_part %0d, want %0d", low_part, want.lo));
				if (fraction !== want.frac)
					report_mismatch($sformatf("fraction %0d, want %0d", fraction, want.frac));
			end
		end
	end

	initial begin : watchdog
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unseeded_start();
		test_seed_extremes();
		test_back_to_back();
		test_random_draws(RAND_ITEMS);
		drain();
		repeat (TAIL_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
